FILE: design/msit_pkg.sv
// ---------------------------------------------------------------------------
// msit_pkg: shared types and constants of the millisecond interval timer
// Item kinds, request and result structs, register image byte offsets.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package msit_pkg;

  // register image layout, big-endian byte offsets
  localparam int unsigned ImgBytes  = 32;
  localparam int unsigned CntBase   = 12;
  localparam int unsigned OfsBase   = 16;
  localparam int unsigned IvlBase   = 20;
  localparam int unsigned StaBase   = 24;
  localparam int unsigned DltBase   = 28;
  localparam int unsigned WrBytes   = ImgBytes - OfsBase;
  localparam int unsigned MaxSize   = 8;

  // request kinds; codes five to seven do nothing
  typedef enum logic [2:0] {
    KIND_TICK    = 3'd0,
    KIND_READ    = 3'd1,
    KIND_WRITE   = 3'd2,
    KIND_PWR_ON  = 3'd3,
    KIND_PWR_OFF = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [4:0]  offset;
    logic [3:0]  size;
    logic [63:0] write_data;
  } item_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        interrupt_pulse;
    logic        running;
  } result_t;

endpackage

`default_nettype wire

FILE: design/msit_timer.sv
// ---------------------------------------------------------------------------
// msit_timer: timer state and per-request update
// Holds the count and timer words, merges bus writes, reads the image and
// checks expiry; all in one pass of combinational logic per request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msit_timer (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             item_en,
  input  wire msit_pkg::item_t  item,
  output msit_pkg::result_t     result
);

  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] ofs_r, ofs_nxt;
  logic [31:0] ivl_r, ivl_nxt;
  logic [31:0] sta_r, sta_nxt;
  logic [31:0] dlt_r, dlt_nxt;
  logic        pwr_r, pwr_nxt;

  logic [3:0]   sz;
  logic [5:0]   end_idx;
  logic         is_write;
  logic [319:0] img_ext;
  logic [319:0] img_shift;
  logic [63:0]  window;
  logic [63:0]  rd_data;
  logic [15:0]  we;
  logic [7:0]   wr_byte [msit_pkg::WrBytes];
  logic [127:0] wimg;
  logic [31:0]  ofs_w, ivl_w, sta_w, dlt_w;
  logic         ofs_t, sta_t, dlt_t;
  logic [31:0]  cnt_a, ofs_a, ivl_a, sta_a, dlt_a;
  logic         pwr_a;
  logic [31:0]  elapsed;
  logic         expire;

  // effective size, clamped to eight bytes
  assign sz       = (item.size > 4'(msit_pkg::MaxSize)) ? 4'(msit_pkg::MaxSize) : item.size;
  assign end_idx  = {1'b0, item.offset} + {2'b00, sz};
  assign is_write = (item.kind == msit_pkg::KIND_WRITE) && pwr_r;

  // read: window of the image at the offset, right aligned to the size
  assign img_ext   = {96'd0, cnt_r, ofs_r, ivl_r, sta_r, dlt_r, 64'd0};
  assign img_shift = img_ext << {item.offset, 3'b000};
  assign window    = img_shift[319:256];
  assign rd_data   = window >> {4'(4'd8 - sz), 3'b000};

  // write byte enables and source bytes for the writable bytes
  always_comb begin
    logic [5:0] idx;
    logic [3:0] k;
    logic [3:0] sh;
    idx = '0;
    k   = '0;
    sh  = '0;
    for (int j = 0; j < msit_pkg::WrBytes; j++) begin
      idx        = 6'(msit_pkg::OfsBase + j);
      k          = 4'(idx - {1'b0, item.offset});
      sh         = 4'(sz - 4'd1 - k);
      we[j]      = is_write && (idx >= {1'b0, item.offset}) && (idx < end_idx);
      wr_byte[j] = 8'(item.write_data >> {sh, 3'b000});
    end
  end

  // byte merge into the timer words
  always_comb begin
    wimg = {ofs_r, ivl_r, sta_r, dlt_r};
    for (int j = 0; j < msit_pkg::WrBytes; j++) begin
      if (we[j]) begin
        wimg[127 - 8*j -: 8] = wr_byte[j];
      end
    end
  end

  assign ofs_w = wimg[127:96];
  assign ivl_w = wimg[95:64];
  assign sta_w = wimg[63:32];
  assign dlt_w = wimg[31:0];
  assign ofs_t = |we[3:0];
  assign sta_t = |we[11:8];
  assign dlt_t = |we[15:12];

  // request action before the expiry check
  always_comb begin
    cnt_a = cnt_r;
    ofs_a = ofs_r;
    ivl_a = ivl_r;
    sta_a = sta_r;
    dlt_a = dlt_r;
    pwr_a = pwr_r;
    unique case (item.kind)
      msit_pkg::KIND_TICK: begin
        cnt_a = cnt_r + 32'd1;
      end
      msit_pkg::KIND_WRITE: begin
        ofs_a = ofs_w;
        ivl_a = ivl_w;
        sta_a = sta_w;
        dlt_a = dlt_w;
        // offset word cleared stops the timer; start or delta write arms it
        priority if (ofs_t && (ofs_w == 32'd0)) begin
          ofs_a = ofs_w;
        end else if (sta_t || dlt_t) begin
          ofs_a = 32'd1;
        end else if (ofs_t) begin
          sta_a = cnt_r;
          dlt_a = ofs_w;
        end
      end
      msit_pkg::KIND_PWR_ON: begin
        pwr_a = 1'b1;
        ofs_a = '0;
        ivl_a = '0;
        sta_a = '0;
        dlt_a = '0;
      end
      msit_pkg::KIND_PWR_OFF: begin
        pwr_a = 1'b0;
        ofs_a = '0;
      end
      default: begin
      end
    endcase
  end

  // expiry check and reload
  assign elapsed = cnt_a - sta_a;
  assign expire  = (ofs_a != 32'd0) && (elapsed >= dlt_a);

  always_comb begin
    cnt_nxt = cnt_a;
    ofs_nxt = ofs_a;
    ivl_nxt = ivl_a;
    sta_nxt = sta_a;
    dlt_nxt = dlt_a;
    pwr_nxt = pwr_a;
    if (expire) begin
      if (ivl_a == 32'd0) begin
        ofs_nxt = '0;
      end else begin
        sta_nxt = sta_a + dlt_a;
        dlt_nxt = ivl_a;
      end
    end
  end

  // result of this request
  assign result.read_data       = (item.kind == msit_pkg::KIND_READ) ? rd_data : 64'd0;
  assign result.interrupt_pulse = expire;
  assign result.running         = (ofs_nxt != 32'd0);

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ofs_r <= '0;
      ivl_r <= '0;
      sta_r <= '0;
      dlt_r <= '0;
      pwr_r <= 1'b0;
    end else if (item_en) begin
      cnt_r <= cnt_nxt;
      ofs_r <= ofs_nxt;
      ivl_r <= ivl_nxt;
      sta_r <= sta_nxt;
      dlt_r <= dlt_nxt;
      pwr_r <= pwr_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/ms_interval_timer_registers.sv
// Flow: a request accepted into the input request register is updated in msit_timer,
// and its result is registered in the result register, from which it is taken.
// Throughput: one request per cycle; a stalled result holds the result register and,
// once the input register is also full, stalls the input.
// Reset: synchronous active-low rst_n clears the count, timer words, power flag
// and all valid flags; no clearing pass.
// ---------------------------------------------------------------------------
// ms_interval_timer_registers: register-mapped millisecond interval timer
// Input request register, single-pass update in msit_timer, result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ms_interval_timer_registers (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_kind,
  input  wire logic [4:0]  in_offset,
  input  wire logic [3:0]  in_size,
  input  wire logic [63:0] in_write_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_read_data,
  output logic             out_interrupt_pulse,
  output logic             out_running
);

  logic               s1_valid_r, s1_valid_nxt;
  msit_pkg::item_t    s1_item_r;
  logic               out_valid_r, out_valid_nxt;
  msit_pkg::result_t  out_res_r;
  msit_pkg::result_t  res;
  logic               in_take;
  logic               advance;

  // request moves to the result register when that register is free or drains
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.kind       <= msit_pkg::kind_t'(in_kind);
      s1_item_r.offset     <= in_offset;
      s1_item_r.size       <= in_size;
      s1_item_r.write_data <= in_write_data;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  // timer state and update
  msit_timer u_timer (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_en (advance),
    .item    (s1_item_r),
    .result  (res)
  );

  assign out_valid           = out_valid_r;
  assign out_read_data       = out_res_r.read_data;
  assign out_interrupt_pulse = out_res_r.interrupt_pulse;
  assign out_running         = out_res_r.running;

endmodule

`default_nettype wire
